FILE: hw/rtl/set_assoc_cache_lru_tracker_assert.svh
// Assertion macros used by the cache tracker datapath.
`ifndef SET_ASSOC_CACHE_LRU_TRACKER_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SALRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SALRU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SALRU_ASSERT(lbl, prop, msg)
`define SALRU_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/salru_pkg.sv
// Types and constants shared by the cache tracker modules.
package salru_pkg;
	// Operation codes.
	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_FETCH = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_OFFSET = 2'd0;
	localparam logic [1:0] CFG_SETS   = 2'd1;
	localparam logic [1:0] CFG_WAYS   = 2'd2;
	localparam logic [1:0] CFG_SPLIT  = 2'd3;

	// Width of the masked set field before the modulo.
	localparam int VW = 15;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] address;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic [1:0]  way_used;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic dec;
		logic mul;
		logic qd;
		logic sub;
		logic sel;
		logic upd;
		logic clr;
		logic clr_rank;
		logic emit;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_access;
		logic is_flush;
		logic clr_last;
	} status_t;
endpackage

FILE: hw/rtl/salru_ram.sv
// Generic single write port RAM with registered read.
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/salru_ctrl.sv
// Controller state machine sequencing lookups, updates and clearing passes.
module salru_ctrl import salru_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);
	typedef enum logic [3:0] {
		ST_CLR_INIT, ST_IDLE, ST_DEC, ST_MUL, ST_QD, ST_SUB, ST_RD,
		ST_SEL, ST_UPD, ST_CLR_FL, ST_EMIT
	} state_t;

	state_t state_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_INIT;
		end else begin
			case (state_q)
				ST_CLR_INIT: if (status.clr_last) state_q <= ST_IDLE;
				ST_IDLE:     if (start) state_q <= ST_DEC;
				ST_DEC: begin
					if (status.is_access) state_q <= ST_MUL;
					else if (status.is_flush) state_q <= ST_CLR_FL;
					else state_q <= ST_EMIT;
				end
				ST_MUL:      state_q <= ST_QD;
				ST_QD:       state_q <= ST_SUB;
				ST_SUB:      state_q <= ST_RD;
				ST_RD:       state_q <= ST_SEL;
				ST_SEL:      state_q <= ST_UPD;
				ST_UPD:      state_q <= ST_IDLE;
				ST_CLR_FL:   if (status.clr_last) state_q <= ST_EMIT;
				ST_EMIT:     state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLR_INIT: begin
				cmd.clr = 1'b1;
				cmd.clr_rank = 1'b1;
			end
			ST_IDLE:   cmd.load = start;
			ST_DEC:    cmd.dec = 1'b1;
			ST_MUL:    cmd.mul = 1'b1;
			ST_QD:     cmd.qd = 1'b1;
			ST_SUB:    cmd.sub = 1'b1;
			ST_SEL:    cmd.sel = 1'b1;
			ST_UPD:    cmd.upd = 1'b1;
			ST_CLR_FL: cmd.clr = 1'b1;
			ST_EMIT:   cmd.emit = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

FILE: hw/rtl/salru_dp.sv
// Datapath: configuration, address split, set stores, way selection and counters.
module salru_dp import salru_pkg::*; #(
	parameter int WAYS      = 4,
	parameter int SETS      = 256,
	parameter int ADDR_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  item_t      item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data,
	output status_t    status,
	output logic       done,
	output result_t    result
);
	`include "set_assoc_cache_lru_tracker_assert.svh"

	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int L  = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int S  = VW + L;
	localparam logic [63:0] MREC = ((64'd1 << S) / SETS) + 64'd1;
	localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [RW-1:0] RMAX = RW'(WAYS - 1);

	// Configuration registers.
	logic [4:0] off_q;
	logic [3:0] sb_q;
	logic [2:0] wu_q;
	logic       split_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 5'd2;
			sb_q <= 4'd8;
			wu_q <= 3'd4;
			split_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET: off_q <= cfg_data;
				CFG_SETS:   sb_q <= cfg_data[3:0];
				CFG_WAYS:   wu_q <= cfg_data[2:0];
				CFG_SPLIT:  split_q <= cfg_data[0];
				default:    off_q <= off_q;
			endcase
		end
	end

	// Ways in use, clamped to the built associativity.
	logic [4:0] nw;
	logic [WAYS-1:0] use_w;
	always_comb begin
		if (wu_q == 3'd0) nw = 5'd1;
		else if (32'(wu_q) > WAYS) nw = 5'(WAYS);
		else nw = {2'b00, wu_q};
		for (int i = 0; i < WAYS; i++) begin
			use_w[i] = (5'(i) < nw);
		end
	end

	// Captured item and decode.
	logic [2:0]  op_q;
	logic [31:0] addr_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= item.op;
			addr_q <= item.address & AMASK;
		end
	end

	assign status.is_flush  = (op_q == OP_FLUSH);
	assign status.is_access = (op_q == OP_READ) || (op_q == OP_WRITE)
		|| ((op_q == OP_FETCH) && !split_q);

	// Address split: set field and tag.
	logic [VW-1:0] v_s1;
	logic [TW-1:0] tag_s1;
	logic [31:0]   shifted;
	logic [15:0]   smask;
	logic [5:0]    tsh;
	logic [31:0]   tag_full;
	always_comb begin
		shifted = addr_q >> off_q;
		smask = (16'd1 << sb_q) - 16'd1;
		tsh = {1'b0, off_q} + {2'b00, sb_q};
		tag_full = addr_q >> tsh;
	end

	// Set index modulo the built set count, by reciprocal multiply.
	logic [31:0] prod_s2;
	logic [31:0] qd_s3;
	logic [SW-1:0] set_s4;
	logic [31:0] diff;
	assign diff = 32'(v_s1) - qd_s3;

	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			v_s1 <= shifted[VW-1:0] & smask[VW-1:0];
			tag_s1 <= tag_full[TW-1:0];
		end
		if (cmd.mul) prod_s2 <= 32'(v_s1) * 32'(MREC[16:0]);
		if (cmd.qd) qd_s3 <= 32'(VW'(prod_s2 >> S)) * 32'(SETS);
		if (cmd.sub) set_s4 <= diff[SW-1:0];
	end

	// Clearing pass counter.
	logic [SW-1:0] clr_cnt_q;
	assign status.clr_last = (clr_cnt_q == SW'(SETS - 1));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= status.clr_last ? '0 : clr_cnt_q + SW'(1);
		end
	end

	// Set stores, one row per set.
	logic [WAYS-1:0]         vrow, vwr;
	logic [WAYS-1:0][RW-1:0] rrow, rwr;
	logic [WAYS-1:0][TW-1:0] trow, twr;
	logic [SW-1:0]           waddr;

	assign waddr = cmd.clr ? clr_cnt_q : set_s4;

	salru_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid (
		.clk(clk), .we(cmd.clr || cmd.upd), .waddr(waddr),
		.wdata(cmd.clr ? '0 : vwr), .raddr(set_s4), .rdata(vrow));
	salru_ram #(.WIDTH(WAYS * RW), .DEPTH(SETS)) u_rank (
		.clk(clk), .we(cmd.clr_rank || cmd.upd), .waddr(waddr),
		.wdata(cmd.clr_rank ? '0 : rwr), .raddr(set_s4), .rdata(rrow));
	salru_ram #(.WIDTH(WAYS * TW), .DEPTH(SETS)) u_tag (
		.clk(clk), .we(cmd.upd), .waddr(waddr),
		.wdata(twr), .raddr(set_s4), .rdata(trow));

	// Way selection: hit first, else first free way, else least recent.
	logic [RW-1:0] hway, fway, lway, way_c;
	logic          found, free;
	logic [RW-1:0] best;
	always_comb begin
		found = 1'b0;
		free = 1'b0;
		hway = '0;
		fway = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (use_w[i] && vrow[i] && (trow[i] == tag_s1)) begin
				found = 1'b1;
				hway = RW'(i);
			end
			if (use_w[i] && !vrow[i]) begin
				free = 1'b1;
				fway = RW'(i);
			end
		end
		best = rrow[0];
		lway = '0;
		for (int i = 1; i < WAYS; i++) begin
			if (use_w[i] && (rrow[i] > best)) begin
				best = rrow[i];
				lway = RW'(i);
			end
		end
		way_c = found ? hway : (free ? fway : lway);
	end

	logic [RW-1:0] way_s6;
	logic          hit_s6;
	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			way_s6 <= way_c;
			hit_s6 <= found;
		end
	end

	// Row update: recency ranks, valid bit and tag of the used way.
	logic [RW-1:0] rsel;
	always_comb begin
		rsel = rrow[way_s6];
		vwr = vrow;
		twr = trow;
		rwr = rrow;
		for (int i = 0; i < WAYS; i++) begin
			if (RW'(i) == way_s6) begin
				rwr[i] = '0;
				if (!hit_s6) begin
					vwr[i] = 1'b1;
					twr[i] = tag_s1;
				end
			end else if (use_w[i] && (rrow[i] <= rsel) && (rrow[i] < RMAX)) begin
				rwr[i] = rrow[i] + RW'(1);
			end
		end
	end

	// Saturating counters and result register.
	logic [31:0] hit_cnt_q, miss_cnt_q;
	logic [31:0] way32;
	assign way32 = 32'(way_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.upd || cmd.emit;
			if (cmd.upd && hit_s6 && (hit_cnt_q != 32'hFFFF_FFFF)) begin
				hit_cnt_q <= hit_cnt_q + 32'd1;
			end
			if (cmd.upd && !hit_s6 && (miss_cnt_q != 32'hFFFF_FFFF)) begin
				miss_cnt_q <= miss_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			result.hit <= hit_s6;
			result.miss <= !hit_s6;
			result.way_used <= way32[1:0];
			result.hit_count <= hit_cnt_q + 32'(hit_s6 && (hit_cnt_q != 32'hFFFF_FFFF));
			result.miss_count <= miss_cnt_q
				+ 32'(!hit_s6 && (miss_cnt_q != 32'hFFFF_FFFF));
		end else if (cmd.emit) begin
			result.hit <= 1'b0;
			result.miss <= 1'b0;
			result.way_used <= 2'd0;
			result.hit_count <= hit_cnt_q;
			result.miss_count <= miss_cnt_q;
		end
	end

	// Checks on the datapath.
	`SALRU_NEVER(a_hit_and_miss, done && result.hit && result.miss, "hit and miss together")
	`SALRU_NEVER(a_clr_upd, cmd.clr && cmd.upd, "row update during clearing pass")
	`SALRU_ASSERT(a_hit_step, cmd.upd && hit_s6 && (hit_cnt_q != 32'hFFFF_FFFF) |=> hit_cnt_q == $past(hit_cnt_q) + 32'd1, "hit count did not advance")
	`SALRU_ASSERT(a_done_src, done |-> $past(cmd.upd) || $past(cmd.emit), "result without a source")
endmodule

FILE: hw/rtl/set_assoc_cache_lru_tracker.sv
// An access steps through the decode, multiply, quotient, subtract, read, select and
// update states, a no-op item through decode and emit; a new item waits for idle.
// A flush walks every set row, one per cycle.
// After reset a clearing pass over every set holds busy high before the first item.
// Each result is shown for one cycle on done; the receiver cannot stall it.
module set_assoc_cache_lru_tracker import salru_pkg::*; #(
	parameter int WAYS      = 4,
	parameter int SETS      = 256,
	parameter int ADDR_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);
	cmd_t    cmd;
	status_t status;

	// Controller.
	salru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.status(status), .cmd(cmd), .busy(busy));

	// Datapath.
	salru_dp #(.WAYS(WAYS), .SETS(SETS), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.status(status), .done(done), .result(result));
endmodule
